// ----- rtl/core/fpa_pkg.sv -----
// shared types and codes of the fixed-point alu core
// no dependencies

`default_nettype none

package fpa_pkg;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_LT       = 4'd4;
    localparam logic [3:0] OP_GT       = 4'd5;
    localparam logic [3:0] OP_LE       = 4'd6;
    localparam logic [3:0] OP_GE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_MIN      = 4'd10;
    localparam logic [3:0] OP_MAX      = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;
    localparam logic [3:0] OP_TO_INT   = 4'd14;
    localparam logic [3:0] OP_FROM_INT = 4'd15;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // quotient bits produced by the divider: enough for 2*|a|*2^F / |b| below 2^34
    localparam int QW = 34;

    // item data that travels beside the divider
    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  st;
        logic        neg;
        logic        bzero;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/core/fixed_point_alu_core.sv -----
// top level of the signed 32-bit fixed-point alu core
// depends on fpa_pkg and fpa_div

`default_nettype none

// usage
//   command channel: drive i_operation, i_operand_a and i_operand_b with start high;
//   the command is taken at any clock edge where start is high and busy is low.
//   busy is held low: the core takes one command per cycle, back to back.
//   result channel: o_done is high for one cycle with o_result_value,
//   o_compare_true and o_status; the transfer completes at the edge that ends it.
//   there is no back pressure, the receiver must take every result.
// ordering
//   every operation takes the same path length so results leave in command order.
//   the length is set by the divider, which resolves one quotient bit per stage over
//   34 stages plus an entry stage.
// throughput: one command per cycle for all operations
// reset: i_rst_n low clears every valid bit, so no result comes out of flushed
//   commands; data registers are not reset

module fixed_point_alu_core
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [3:0]         i_operation,
    input  wire  signed [31:0] i_operand_a,
    input  wire  signed [31:0] i_operand_b,
    output logic               o_done,
    output logic signed [31:0] o_result_value,
    output logic               o_compare_true,
    output logic [1:0]         o_status
);

    localparam int DLAT = QW + 1;       // divider register depth
    localparam int NDLY = DLAT - 3;     // side delay after the multiply stages
    localparam int VLEN = DLAT + 1;

    // valid bits, one per stage up to the divider output
    logic [VLEN-1:0] r_vld;
    logic [VLEN-1:0] n_vld;

    // stage 1: registered command
    logic [3:0]         r1_op;
    logic signed [31:0] r1_a;
    logic signed [31:0] r1_b;

    // stage 2
    t_side              r_s2;
    t_side              n_s2;
    logic signed [63:0] r_prod;

    // stage 3: rounded product magnitude
    t_side              r_s3;
    t_side              n_s3;
    logic [63:0]        r_mag;
    logic [63:0]        n_mag;
    logic [63:0]        w_absp;

    // stage 4: finished multiply
    t_side              r_s4;
    t_side              n_s4;

    t_side              r_dly [0:NDLY-1];

    // divider
    logic [31+FRACTION_BITS:0] w_na;
    logic [31:0]               w_nb;
    logic [QW-1:0]             w_t;
    logic                      w_ovf;

    // output stage
    logic               r_done;
    logic signed [31:0] r_res;
    logic               r_cmp;
    logic [1:0]         r_st;
    logic signed [31:0] n_res;
    logic [1:0]         n_st;
    t_side              w_end;
    logic [QW:0]        w_q;
    logic [QW:0]        w_lim;

    // stage 2 helpers
    logic signed [32:0]               w_a33;
    logic signed [32:0]               w_b33;
    logic signed [32:0]               w_sum;
    logic signed [32:0]               w_dif;
    logic signed [31+FRACTION_BITS:0] w_fi;
    logic                             w_fi_ok;
    logic                             w_lt;
    logic                             w_eq;

    assign busy = 1'b0;

    assign n_vld = {r_vld[VLEN-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_done <= r_vld[VLEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op <= i_operation;
        r1_a  <= i_operand_a;
        r1_b  <= i_operand_b;
    end

    // stage 2: all simple operations finish here, multiply starts
    always_comb begin
        w_a33 = {r1_a[31], r1_a};
        if (r1_op == OP_INC || r1_op == OP_DEC) begin
            w_b33 = 33'sd1;
        end else begin
            w_b33 = {r1_b[31], r1_b};
        end
        w_sum   = w_a33 + w_b33;
        w_dif   = w_a33 - w_b33;
        w_fi    = {{FRACTION_BITS{r1_a[31]}}, r1_a} <<< FRACTION_BITS;
        w_fi_ok = (&w_fi[31+FRACTION_BITS:31]) | ~(|w_fi[31+FRACTION_BITS:31]);
        w_lt    = (r1_a < r1_b);
        w_eq    = (r1_a == r1_b);

        n_s2       = '0;
        n_s2.op    = r1_op;
        n_s2.neg   = r1_a[31] ^ r1_b[31];
        n_s2.bzero = (r1_b == 32'sd0);
        case (r1_op)
            OP_ADD, OP_INC: begin
                if (w_sum[32] != w_sum[31]) begin
                    n_s2.res = w_sum[32] ? SAT_MIN : SAT_MAX;
                    n_s2.st  = ST_SAT;
                end else begin
                    n_s2.res = w_sum[31:0];
                end
            end
            OP_SUB, OP_DEC: begin
                if (w_dif[32] != w_dif[31]) begin
                    n_s2.res = w_dif[32] ? SAT_MIN : SAT_MAX;
                    n_s2.st  = ST_SAT;
                end else begin
                    n_s2.res = w_dif[31:0];
                end
            end
            OP_LT:  n_s2.cmp = w_lt;
            OP_GT:  n_s2.cmp = ~w_lt & ~w_eq;
            OP_LE:  n_s2.cmp = w_lt | w_eq;
            OP_GE:  n_s2.cmp = ~w_lt;
            OP_EQ:  n_s2.cmp = w_eq;
            OP_NE:  n_s2.cmp = ~w_eq;
            OP_MIN: n_s2.res = w_lt ? r1_a : r1_b;
            OP_MAX: n_s2.res = (~w_lt & ~w_eq) ? r1_a : r1_b;
            OP_TO_INT: n_s2.res = r1_a >>> FRACTION_BITS;
            OP_FROM_INT: begin
                if (w_fi_ok) begin
                    n_s2.res = w_fi[31:0];
                end else begin
                    n_s2.res = r1_a[31] ? SAT_MIN : SAT_MAX;
                    n_s2.st  = ST_SAT;
                end
            end
            default: ;  // mul and div finish further down
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s2   <= n_s2;
        r_prod <= r1_a * r1_b;
    end

    // stage 3: product magnitude with the rounding half added
    assign w_absp = r_prod[63] ? (64'd0 - r_prod) : r_prod;
    assign n_mag  = (w_absp + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;

    // multiply takes its sign from the product
    always_comb begin
        n_s3 = r_s2;
        if (r_s2.op == OP_MUL) begin
            n_s3.neg = r_prod[63];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3  <= n_s3;
        r_mag <= n_mag;
    end

    // stage 4: sign and saturate the product
    always_comb begin
        n_s4 = r_s3;
        if (r_s3.op == OP_MUL) begin
            if (r_s3.neg ? (r_mag > 64'h8000_0000) : (r_mag > 64'h7fff_ffff)) begin
                n_s4.res = r_s3.neg ? SAT_MIN : SAT_MAX;
                n_s4.st  = ST_SAT;
            end else begin
                n_s4.res = r_s3.neg ? (32'd0 - r_mag[31:0]) : r_mag[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4 <= n_s4;
    end

    // delay line that keeps side data aligned with the divider
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_s4;
        for (int i = 1; i < NDLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    // divider operands from stage 1
    assign w_na = {FRACTION_BITS'(0), (r1_a[31] ? (32'd0 - r1_a) : r1_a)} << FRACTION_BITS;
    assign w_nb = r1_b[31] ? (32'd0 - r1_b) : r1_b;

    fpa_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk (i_clk),
        .i_na  (w_na),
        .i_nb  (w_nb),
        .o_t   (w_t),
        .o_ovf (w_ovf)
    );

    // final stage: round the quotient, merge with the side path
    assign w_end = r_dly[NDLY-1];
    assign w_q   = ({1'b0, w_t} + {{QW{1'b0}}, 1'b1}) >> 1;
    assign w_lim = w_end.neg ? (QW+1)'(33'h0_8000_0000) : (QW+1)'(33'h0_7fff_ffff);

    always_comb begin
        n_res = w_end.res;
        n_st  = w_end.st;
        if (w_end.op == OP_DIV) begin
            if (w_end.bzero) begin
                n_res = '0;
                n_st  = ST_DZ;
            end else if (w_ovf || (w_q > w_lim)) begin
                n_res = w_end.neg ? SAT_MIN : SAT_MAX;
                n_st  = ST_SAT;
            end else begin
                n_res = w_end.neg ? (32'd0 - w_q[31:0]) : w_q[31:0];
                n_st  = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_cmp <= w_end.cmp;
        r_st  <= n_st;
    end

    assign o_done         = r_done;
    assign o_result_value = r_res;
    assign o_compare_true = r_cmp;
    assign o_status       = r_st;

    // a true comparison result carries a zero value and ok status
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_compare_true) |-> (o_result_value == 32'sd0 && o_status == ST_OK))
        else $error("comparison result with value or status");

    // divide by zero gives zero and no flag
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_DZ) |-> (o_result_value == 32'sd0 && !o_compare_true))
        else $error("divide by zero result not clean");

    // saturation always lands on a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_SAT) |->
            (o_result_value == SAT_MAX || o_result_value == SAT_MIN))
        else $error("saturated result off the limits");

    // the strobe is registered from the last valid stage and rises in the cycle after it
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[VLEN-1] |=> o_done)
        else $error("result strobe lost");

endmodule

`default_nettype wire

// ----- rtl/core/fpa_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on fpa_pkg

`default_nettype none

module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  wire                         i_clk,
    input  wire  [31+FRACTION_BITS:0]   i_na,
    input  wire  [31:0]                 i_nb,
    output logic [QW-1:0]               o_t,
    output logic                        o_ovf
);

    localparam int NW  = QW + 32;
    localparam int PAD = NW - (33 + FRACTION_BITS);

    logic [NW-1:0]  w_num;
    logic [31:0]    r_rem [0:QW];
    logic [QW-1:0]  r_num [0:QW];
    logic [31:0]    r_nb  [0:QW];
    logic [QW-1:0]  r_q   [0:QW];
    logic           r_ovf [0:QW];

    // dividend is 2*na so that the last quotient bit gives the rounding half
    assign w_num = {{PAD{1'b0}}, i_na, 1'b0};

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_num[NW-1:QW];
        r_num[0] <= w_num[QW-1:0];
        r_nb[0]  <= i_nb;
        r_q[0]   <= '0;
        r_ovf[0] <= (w_num[NW-1:QW] >= i_nb);
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_stage
            logic [32:0] w_r2;
            logic        w_ge;
            logic [32:0] w_diff;
            assign w_r2   = {r_rem[k-1], r_num[k-1][QW-k]};
            assign w_ge   = (w_r2 >= {1'b0, r_nb[k-1]});
            assign w_diff = w_r2 - {1'b0, r_nb[k-1]};
            always_ff @(posedge i_clk) begin
                r_rem[k] <= w_ge ? w_diff[31:0] : w_r2[31:0];
                r_num[k] <= r_num[k-1];
                r_nb[k]  <= r_nb[k-1];
                r_q[k]   <= {r_q[k-1][QW-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    endgenerate

    assign o_t   = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench of the fixed-point alu core
// depends on fpa_pkg and fixed_point_alu_core (with fpa_div)

`default_nettype none

module testbench
    import fpa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 8;

    // one directed row; chk set where the expected result is typed in
    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        bit                 chk;
        logic signed [31:0] r;
        logic               c;
        logic [1:0]         st;
    } t_row;

    typedef struct {
        logic signed [31:0] r;
        logic               c;
        logic [1:0]         st;
    } t_alu_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [3:0]         i_operation = OP_ADD;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_done;
    logic signed [31:0] o_result_value;
    logic               o_compare_true;
    logic [1:0]         o_status;

    t_alu_res pending_results[$];
    int       n_mismatch = 0;
    bit       stim_done = 1'b0;

    fixed_point_alu_core #(.FRACTION_BITS(FB)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_compare_true (o_compare_true),
        .o_status       (o_status)
    );

    always #4 i_clk = ~i_clk;

    // clamp a wide exact value into 32 bits, flagging saturation
    function automatic t_alu_res saturate(longint v);
        t_alu_res s;
        s.c = 1'b0;
        s.st = ST_OK;
        if (v > 64'sd2147483647) begin
            s.r = SAT_MAX;
            s.st = ST_SAT;
        end else if (v < -64'sd2147483648) begin
            s.r = SAT_MIN;
            s.st = ST_SAT;
        end else begin
            s.r = v[31:0];
        end
        return s;
    endfunction

    // exact q-format arithmetic, rounding half away from zero
    function automatic t_alu_res alu_result(logic [3:0] op, logic signed [31:0] a,
                                            logic signed [31:0] b);
        t_alu_res s;
        longint wa, wb, p;
        longint unsigned m, na, nb, q;
        wa = a;
        wb = b;
        s = '{r: '0, c: 1'b0, st: ST_OK};
        case (op)
            OP_ADD: s = saturate(wa + wb);
            OP_SUB: s = saturate(wa - wb);
            OP_MUL: begin
                p = wa * wb;
                m = (p < 0) ? -p : p;
                m = (m + (64'd1 << (FB - 1))) >> FB;
                s = saturate((p < 0) ? -longint'(m) : longint'(m));
            end
            OP_DIV: begin
                if (wb == 0) begin
                    s.st = ST_DZ;
                end else begin
                    na = ((wa < 0) ? -wa : wa) << FB;
                    nb = (wb < 0) ? -wb : wb;
                    q = (2 * na + nb) / (2 * nb);
                    s = saturate(((wa < 0) != (wb < 0)) ? -longint'(q) : longint'(q));
                end
            end
            OP_LT: s.c = a < b;
            OP_GT: s.c = a > b;
            OP_LE: s.c = a <= b;
            OP_GE: s.c = a >= b;
            OP_EQ: s.c = a == b;
            OP_NE: s.c = a != b;
            OP_MIN: s.r = (a < b) ? a : b;
            OP_MAX: s.r = (a > b) ? a : b;
            OP_INC: s = saturate(wa + 1);
            OP_DEC: s = saturate(wa - 1);
            OP_TO_INT: s.r = a >>> FB;
            default: s = saturate(wa * (64'sd1 << FB));
        endcase
        return s;
    endfunction

    // operand with a bias toward edge values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return SAT_MAX - $urandom_range(0, 3);
            1: return SAT_MIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return $urandom_range(0, 2047) - 1024;
            4: return $urandom_range(0, 32'hffff) - 32'h8000;
            default: return $urandom;
        endcase
    endfunction

    // issue one command, holding start until the transfer happens
    task automatic send_command(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit chk,
                                t_alu_res typed);
        t_alu_res model;
        model = alu_result(op, a, b);
        if (chk && (model.r !== typed.r || model.c !== typed.c || model.st !== typed.st))
            $display("directed row disagrees with model: op %0d a %h b %h", op, a, b);
        start <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(chk ? typed : model);
    endtask

    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            5, 6, 7, 8: n = $urandom_range(1, 3);
            default: n = $urandom_range(4, 40);
        endcase
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // result side: every strobe completes a transfer at the next edge
    always @(posedge i_clk) begin
        t_alu_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h cmp %b st %0d",
                             o_result_value, o_compare_true, o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.r || o_compare_true !== want.c ||
                    o_status !== want.st) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %h/%b/%0d got %h/%b/%0d", want.r, want.c,
                                 want.st, o_result_value, o_compare_true, o_status);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_alu_res typed;
        int k;
        // add/sub saturation both ways, mul/div rounding, divide by zero, compares, min/max, inc/dec and conversions
        rows.push_back('{OP_ADD, 32'h7fffffff, 32'sd1, 1, SAT_MAX, 1'b0, ST_SAT});
        rows.push_back('{OP_ADD, 32'h80000000, -32'sd1, 1, SAT_MIN, 1'b0, ST_SAT});
        rows.push_back('{OP_SUB, 32'h80000000, 32'sd1, 1, SAT_MIN, 1'b0, ST_SAT});
        rows.push_back('{OP_SUB, 32'sd0, 32'h80000000, 1, SAT_MAX, 1'b0, ST_SAT});
        rows.push_back('{OP_MUL, 32'h7fffffff, 32'h7fffffff, 1, SAT_MAX, 1'b0, ST_SAT});
        rows.push_back('{OP_MUL, 32'h80000000, 32'h80000000, 1, SAT_MAX, 1'b0, ST_SAT});
        rows.push_back('{OP_MUL, 32'sd1, 32'sd128, 1, 32'sd1, 1'b0, ST_OK});
        rows.push_back('{OP_MUL, -32'sd1, 32'sd128, 1, -32'sd1, 1'b0, ST_OK});
        rows.push_back('{OP_DIV, 32'sd5, 32'sd0, 1, 32'sd0, 1'b0, ST_DZ});
        rows.push_back('{OP_DIV, 32'h80000000, 32'sd0, 1, 32'sd0, 1'b0, ST_DZ});
        rows.push_back('{OP_DIV, 32'h80000000, 32'sd1, 1, SAT_MIN, 1'b0, ST_SAT});
        rows.push_back('{OP_DIV, 32'h80000000, -32'sd1, 1, SAT_MAX, 1'b0, ST_SAT});
        rows.push_back('{OP_DIV, 32'sd1, 32'sd512, 1, 32'sd1, 1'b0, ST_OK});
        rows.push_back('{OP_LT, 32'h80000000, 32'h7fffffff, 1, 32'sd0, 1'b1, ST_OK});
        rows.push_back('{OP_GT, 32'h80000000, 32'h7fffffff, 1, 32'sd0, 1'b0, ST_OK});
        rows.push_back('{OP_LE, 32'sd7, 32'sd7, 1, 32'sd0, 1'b1, ST_OK});
        rows.push_back('{OP_GE, -32'sd7, 32'sd7, 1, 32'sd0, 1'b0, ST_OK});
        rows.push_back('{OP_EQ, 32'sd7, 32'sd7, 1, 32'sd0, 1'b1, ST_OK});
        rows.push_back('{OP_NE, 32'sd7, 32'sd7, 1, 32'sd0, 1'b0, ST_OK});
        rows.push_back('{OP_MIN, 32'h80000000, 32'h7fffffff, 0, 0, 0, ST_OK});
        rows.push_back('{OP_MAX, 32'h80000000, 32'h7fffffff, 0, 0, 0, ST_OK});
        rows.push_back('{OP_INC, 32'h7fffffff, 32'hffffffff, 1, SAT_MAX, 1'b0, ST_SAT});
        rows.push_back('{OP_DEC, 32'h80000000, 32'hffffffff, 1, SAT_MIN, 1'b0, ST_SAT});
        rows.push_back('{OP_TO_INT, -32'sd1, 32'sd0, 1, -32'sd1, 1'b0, ST_OK});
        rows.push_back('{OP_FROM_INT, 32'h00800000, 32'sd0, 1, SAT_MAX, 1'b0, ST_SAT});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            typed = '{r: rows[i].r, c: rows[i].c, st: rows[i].st};
            send_command(rows[i].op, rows[i].a, rows[i].b, rows[i].chk, typed);
            if (i % 7 == 6) idle_gap();
        end
        // random part: long back-to-back stretches alternate with gappy ones
        for (k = 0; k < 1500; k++) begin
            send_command(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), 0, typed);
            if ((k / 200) % 2 == 1) idle_gap();
        end
        start <= 1'b0;

        // let the pipeline drain, then keep watching for stray results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2ms;
        $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
